// File: hdl/scanline_polygon_span_fill_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scanline span fill block
// Shared property wrappers used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SCANLINE_POLYGON_SPAN_FILL_ASSERT_SVH
`define SCANLINE_POLYGON_SPAN_FILL_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SPF_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define SPF_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Types and constants of the scanline span fill block.
// ----------------------------------------------------------------------------
package spf_pkg;
  localparam int MaxVertices = 16;
  localparam int CoordBits   = 10;
  localparam int IdxBits     = $clog2(MaxVertices);
  localparam int CntBits     = IdxBits + 1;
  localparam int MaxResults  = 8;

  localparam logic [1:0] OpStart  = 2'd0;
  localparam logic [1:0] OpAppend = 2'd1;
  localparam logic [1:0] OpQuery  = 2'd2;
  localparam logic [1:0] OpNop    = 2'd3;

  localparam int DivBits = 2 * CoordBits + 1;

  typedef logic [CoordBits-1:0] coord_t;

  // controller to datapath
  typedef struct packed {
    logic             capture;    // latch input word
    logic             store_vtx;  // write vertex store at vertex_total
    logic             start_poly; // reset vertex_total to one
    logic             edge_load;  // latch edge endpoints (read data valid)
    logic             mul_go;     // latch |dx|, |dy|, |y-y0| and sign
    logic             div_init;   // load divider
    logic             div_step;   // one quotient bit
    logic             cross_push; // insert crossing into sorted list
    logic             sort_clr;   // clear sorted count
    logic             sort_ins;   // not used; cross_push does the insertion
    logic             emit;       // present result
    logic             emit_empty; // empty-line result
    logic [IdxBits-1:0] rd_idx;   // vertex read address
  } spf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0]       op;
    logic [CntBits-1:0] total;
    logic             hit;
    logic [CntBits-1:0] ncross;
  } spf_sts_t;
endpackage

// File: hdl/spf_ram.sv
// ----------------------------------------------------------------------------
// spf_ram
// Generic single-port-write, single-read RAM with registered read.
// ----------------------------------------------------------------------------
module spf_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/spf_datapath.sv
// ----------------------------------------------------------------------------
// spf_datapath
// Vertex store, edge test, crossing divider, sorted crossing list, results.
// ----------------------------------------------------------------------------
module spf_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  spf_pkg::spf_cmd_t     cmd,
  output spf_pkg::spf_sts_t     sts,
  input  logic [1:0]            operation,
  input  logic [spf_pkg::CoordBits-1:0] x_coord,
  input  logic [spf_pkg::CoordBits-1:0] y_coord,
  input  logic [spf_pkg::IdxBits-1:0]   out_idx,
  output logic [spf_pkg::CoordBits-1:0] line_y,
  output logic [spf_pkg::CoordBits-1:0] span_start,
  output logic [spf_pkg::CoordBits:0]   span_end,
  output logic                  empty_line
);
  localparam int CB = spf_pkg::CoordBits;
  localparam int IB = spf_pkg::IdxBits;
  localparam int NB = spf_pkg::CntBits;
  localparam int DB = spf_pkg::DivBits;

  logic [1:0]    op;
  logic [CB-1:0] xin, yin;
  logic [NB-1:0] total;
  logic          we;
  logic [IB-1:0] waddr;
  logic [CB-1:0] rx, ry;

  assign we    = cmd.store_vtx &&
                 (cmd.start_poly || total < NB'(spf_pkg::MaxVertices));
  assign waddr = cmd.start_poly ? '0 : total[IB-1:0];

  spf_ram #(.Width(CB), .Depth(spf_pkg::MaxVertices)) u_xram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(xin), .raddr(cmd.rd_idx), .rdata(rx)
  );
  spf_ram #(.Width(CB), .Depth(spf_pkg::MaxVertices)) u_yram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(yin), .raddr(cmd.rd_idx), .rdata(ry)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= operation;
      xin <= x_coord;
      yin <= y_coord;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (cmd.store_vtx && cmd.start_poly) begin
      total <= NB'(1);
    end else if (we) begin
      total <= total + NB'(1);
    end
  end

  // edge endpoints: first read gives start vertex, second gives end vertex
  logic [CB-1:0] x0, y0, x1, y1;
  logic          second;
  always_ff @(posedge clk) begin
    if (rst) begin
      second <= 1'b0;
    end else if (cmd.edge_load) begin
      second <= ~second;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.edge_load) begin
      if (!second) begin
        x0 <= rx;
        y0 <= ry;
      end else begin
        x1 <= rx;
        y1 <= ry;
      end
    end
  end

  logic hit;
  assign hit = (y0 <= yin && y1 > yin) || (y0 > yin && y1 <= yin);

  // |dx|*|y-y0| / |dy| with sign handled for floor
  logic          neg;
  logic [CB-1:0] adx, ady, ayl;
  logic [DB-1:0] rem;
  logic [2*CB-1:0] quo;
  logic [CB-1:0] dvs;

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      adx    <= (x1 >= x0) ? x1 - x0 : x0 - x1;
      ady    <= (y1 >= y0) ? y1 - y0 : y0 - y1;
      ayl    <= (yin >= y0) ? yin - y0 : y0 - yin;
      neg    <= (x1 < x0) ^ (yin < y0) ^ (y1 < y0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo  <= adx * ayl;
      dvs  <= ady;
      rem  <= '0;
    end else if (cmd.div_step) begin
      logic [DB-1:0] r2;
      r2 = {rem[DB-2:0], quo[2*CB-1]};
      if (r2 >= DB'(dvs)) begin
        rem <= r2 - DB'(dvs);
        quo <= {quo[2*CB-2:0], 1'b1};
      end else begin
        rem <= r2;
        quo <= {quo[2*CB-2:0], 1'b0};
      end
    end
  end

  // crossing value: x0 + floor(+-q), clamped to 0..1023 (negatives round down)
  logic signed [2*CB+2:0] xv;
  logic [CB-1:0] xcl;
  always_comb begin
    if (neg) begin
      xv = $signed({3'b000, x0}) - $signed({3'b000, quo})
           - ((rem != '0) ? (2*CB+3)'(1) : '0);
    end else begin
      xv = $signed({3'b000, x0}) + $signed({3'b000, quo});
    end
    if (xv < 0) begin
      xcl = '0;
    end else if (xv > $signed((2*CB+3)'({CB{1'b1}}))) begin
      xcl = '1;
    end else begin
      xcl = xv[CB-1:0];
    end
  end

  // sorted crossing list kept by insertion on push
  logic [CB-1:0] clist [spf_pkg::MaxVertices];
  logic [NB-1:0] ncross;
  always_ff @(posedge clk) begin
    if (rst || cmd.sort_clr) begin
      ncross <= '0;
    end else if (cmd.cross_push && ncross < NB'(spf_pkg::MaxVertices)) begin
      ncross <= ncross + NB'(1);
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.cross_push && ncross < NB'(spf_pkg::MaxVertices)) begin
      for (int i = 0; i < spf_pkg::MaxVertices; i++) begin
        if (NB'(i) < ncross) begin
          if (clist[i] > xcl) begin
            clist[i] <= (i == 0) ? xcl :
                        ((clist[(i > 0) ? i - 1 : 0] > xcl) ?
                         clist[(i > 0) ? i - 1 : 0] : xcl);
          end
        end else if (NB'(i) == ncross) begin
          clist[i] <= (i == 0) ? xcl :
                      ((clist[(i > 0) ? i - 1 : 0] > xcl) ?
                       clist[(i > 0) ? i - 1 : 0] : xcl);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      line_y     <= yin;
      span_start <= cmd.emit_empty ? '0 : clist[{out_idx[IB-2:0], 1'b0}];
      span_end   <= cmd.emit_empty ? '0 :
                    {1'b0, clist[{out_idx[IB-2:0], 1'b1}]} + (CB+1)'(1);
      empty_line <= cmd.emit_empty;
    end
  end

  assign sts.op     = op;
  assign sts.total  = total;
  assign sts.hit    = hit;
  assign sts.ncross = ncross;
endmodule

// File: hdl/spf_ctrl.sv
// ----------------------------------------------------------------------------
// spf_ctrl
// Sequencer: vertex writes, edge walk, division steps, span output.
// ----------------------------------------------------------------------------
module spf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output spf_pkg::spf_cmd_t   cmd,
  input  spf_pkg::spf_sts_t   sts,
  output logic [spf_pkg::IdxBits-1:0] out_idx,
  output logic                done,
  output logic                last_span
);
  localparam int IB = spf_pkg::IdxBits;
  localparam int NB = spf_pkg::CntBits;
  localparam int QB = $clog2(2 * spf_pkg::CoordBits + 1);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DEC   = 11'b00000000010,
    S_RD0   = 11'b00000000100,
    S_RD1   = 11'b00000001000,
    S_LD1   = 11'b00000010000,
    S_TEST  = 11'b00000100000,
    S_MUL   = 11'b00001000000,
    S_DINIT = 11'b00010000000,
    S_DIV   = 11'b00100000000,
    S_PUSH  = 11'b01000000000,
    S_EMIT  = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic [NB-1:0] eidx;
  logic [QB-1:0] dcnt;
  logic [NB-1:0] pairs;
  logic [IB-1:0] oidx;

  logic [NB-1:0] nxt_e;
  assign nxt_e = (eidx + NB'(1) < sts.total) ? eidx + NB'(1) : '0;

  always_comb begin
    cmd = '0;
    state_next = state;
    cmd.rd_idx = eidx[IB-1:0];
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        cmd.sort_clr = 1'b1;
        if (sts.op == spf_pkg::OpStart) begin
          cmd.store_vtx  = 1'b1;
          cmd.start_poly = 1'b1;
          state_next     = S_IDLE;
        end else if (sts.op == spf_pkg::OpAppend) begin
          cmd.store_vtx = 1'b1;
          state_next    = S_IDLE;
        end else if (sts.op == spf_pkg::OpQuery) begin
          state_next = (sts.total < NB'(2)) ? S_EMIT : S_RD0;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RD0: state_next = S_RD1;
      S_RD1: begin
        cmd.edge_load = 1'b1;
        cmd.rd_idx    = nxt_e[IB-1:0];
        state_next    = S_LD1;
      end
      S_LD1: begin
        cmd.rd_idx = nxt_e[IB-1:0];
        state_next = S_TEST;
      end
      S_TEST: begin
        cmd.edge_load = 1'b1;
        state_next    = S_MUL;
      end
      S_MUL: begin
        if (sts.hit) begin
          cmd.mul_go = 1'b1;
          state_next = S_DINIT;
        end else begin
          state_next = (eidx + NB'(1) < sts.total) ? S_RD0 : S_EMIT;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (dcnt == QB'(2 * spf_pkg::CoordBits - 1)) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.cross_push = 1'b1;
        state_next = (eidx + NB'(1) < sts.total) ? S_RD0 : S_EMIT;
      end
      S_EMIT: begin
        cmd.emit       = 1'b1;
        cmd.emit_empty = (pairs == '0);
        if (pairs == '0 || NB'(oidx) + NB'(1) >= pairs) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      eidx  <= '0;
      dcnt  <= '0;
      oidx  <= '0;
      done  <= 1'b0;
      last_span <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.emit;
      last_span <= cmd.emit && (state_next == S_IDLE);
      if (state == S_DEC) begin
        eidx <= '0;
        oidx <= '0;
      end else if (state == S_MUL && !sts.hit) begin
        eidx <= eidx + NB'(1);
      end else if (state == S_PUSH) begin
        eidx <= eidx + NB'(1);
      end
      if (state == S_DINIT) begin
        dcnt <= '0;
      end else if (state == S_DIV) begin
        dcnt <= dcnt + QB'(1);
      end
      if (state == S_EMIT) begin
        oidx <= oidx + IB'(1);
      end
    end
  end

  always_comb begin
    pairs = {1'b0, sts.ncross[NB-1:1]};
    if (pairs > NB'(spf_pkg::MaxResults)) begin
      pairs = NB'(spf_pkg::MaxResults);
    end
  end

  assign out_idx = oidx;
  assign busy    = (state != S_IDLE);
endmodule

// File: hdl/scanline_polygon_span_fill.sv
// ----------------------------------------------------------------------------
// scanline_polygon_span_fill
// Polygon store with scanline span queries.
// ----------------------------------------------------------------------------
// Usage: drive operation, x_coord, y_coord and raise start while busy is low;
// the word is taken at that edge. Operation 0 starts a polygon with the
// vertex, 1 appends one (dropped when 16 are stored), 2 queries scanline
// y_coord, 3 does nothing.
// A query walks each edge through states RD0, RD1, LD1, TEST and MUL; an edge
// that crosses the line adds DINIT, a 20-step restoring divider and PUSH.
// Results follow as one word per cycle on line_y, span_start, span_end,
// empty_line, last_span, marked by valid for one cycle; the receiver cannot
// stall. A line with no crossings gives one word with empty_line set.
// Reset clears the vertex count and the sequencer; stores need no clearing.
// ----------------------------------------------------------------------------
`include "scanline_polygon_span_fill_assert.svh"

module scanline_polygon_span_fill (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [spf_pkg::CoordBits-1:0] x_coord,
  input  logic [spf_pkg::CoordBits-1:0] y_coord,
  output logic        valid,
  output logic [spf_pkg::CoordBits-1:0] line_y,
  output logic [spf_pkg::CoordBits-1:0] span_start,
  output logic [spf_pkg::CoordBits:0]   span_end,
  output logic        empty_line,
  output logic        last_span
);
  spf_pkg::spf_cmd_t cmd;
  spf_pkg::spf_sts_t sts;
  logic [spf_pkg::IdxBits-1:0] out_idx;

  spf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .sts(sts),
    .out_idx(out_idx), .done(valid), .last_span(last_span)
  );

  spf_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .operation(operation), .x_coord(x_coord), .y_coord(y_coord),
    .out_idx(out_idx), .line_y(line_y), .span_start(span_start),
    .span_end(span_end), .empty_line(empty_line)
  );

  `SPF_ASSERT_IMP(a_last_valid, clk, rst, last_span, valid)
  `SPF_ASSERT_IMP(a_empty_last, clk, rst, valid && empty_line, last_span)
  `SPF_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scanline span fill block: builds polygons,
// queries scanlines and compares every span word against a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  typedef struct {
    logic [9:0]  ly;
    logic [9:0]  s;
    logic [10:0] e;
    logic        emp;
    logic        last;
  } span_t;

  class span_scoreboard;
    logic [9:0] vx[spf_pkg::MaxVertices];
    logic [9:0] vy[spf_pkg::MaxVertices];
    int         nvtx;
    span_t      pending[$];
    int         errors;
    int         checked;

    function void note_word(logic [1:0] op, logic [9:0] xc, logic [9:0] yc);
      longint x0, y0, x1, y1, yl, dx, q, r, xv;
      int     xs[$];
      int     nx, pairs, cnt;
      span_t  sp;
      if (op == spf_pkg::OpStart) begin
        vx[0] = xc; vy[0] = yc; nvtx = 1;
      end else if (op == spf_pkg::OpAppend) begin
        if (nvtx < spf_pkg::MaxVertices) begin
          vx[nvtx] = xc; vy[nvtx] = yc; nvtx++;
        end
      end else if (op == spf_pkg::OpQuery) begin
        yl = yc;
        for (int i = 0; i < nvtx; i++) begin
          nx = (i + 1 < nvtx) ? i + 1 : 0;
          x0 = vx[i]; y0 = vy[i]; x1 = vx[nx]; y1 = vy[nx];
          if ((y0 <= yl && y1 > yl) || (y0 > yl && y1 <= yl)) begin
            dx = (x1 - x0) * (yl - y0);
            q = dx / (y1 - y0);
            r = dx % (y1 - y0);
            if (r != 0 && ((r < 0) != ((y1 - y0) < 0))) q--;
            xv = x0 + q;
            if (xv < 0) xv = 0;
            if (xv > 1023) xv = 1023;
            xs.push_back(int'(xv));
          end
        end
        xs.sort();
        pairs = xs.size() / 2;
        if (pairs == 0) begin
          sp = '{yc, 10'd0, 11'd0, 1'b1, 1'b1};
          pending.push_back(sp);
        end else begin
          cnt = pairs > spf_pkg::MaxResults ? spf_pkg::MaxResults : pairs;
          for (int i = 0; i < cnt; i++) begin
            sp.ly = yc; sp.s = 10'(xs[2*i]); sp.e = 11'(xs[2*i+1] + 1);
            sp.emp = 0; sp.last = (i + 1 == cnt);
            pending.push_back(sp);
          end
        end
      end
    endfunction

    function void check_span(span_t got);
      span_t w;
      checked++;
      if (pending.size() == 0) begin
        $error("unexpected span word line_y=%0d", got.ly);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.ly !== w.ly) begin
        $error("line_y exp %0d got %0d", w.ly, got.ly); errors++;
      end
      if (got.s !== w.s) begin
        $error("span_start exp %0d got %0d", w.s, got.s); errors++;
      end
      if (got.e !== w.e) begin
        $error("span_end exp %0d got %0d", w.e, got.e); errors++;
      end
      if (got.emp !== w.emp) begin
        $error("empty_line exp %0d got %0d", w.emp, got.emp); errors++;
      end
      if (got.last !== w.last) begin
        $error("last_span exp %0d got %0d", w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  operation = 0;
  logic [9:0]  x_coord = 0;
  logic [9:0]  y_coord = 0;
  logic        valid;
  logic [9:0]  line_y;
  logic [9:0]  span_start;
  logic [10:0] span_end;
  logic        empty_line;
  logic        last_span;

  span_scoreboard sb = new();
  int idle_cycles = 0;
  int burst_left = 0;
  int words_sent = 0;
  int queries = 0;
  localparam int WatchLimit = 20000;

  always #5 clk = ~clk;

  scanline_polygon_span_fill DUT (.*);

  always @(posedge clk) begin
    if (!rst) begin
      if (valid) sb.check_span('{line_y, span_start, span_end, empty_line, last_span});
      if ((start && !busy) || valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchLimit) begin
        $display("FAIL scanline_polygon_span_fill");
        $finish;
      end
    end
  end

  task automatic send_word(logic [1:0] op, logic [9:0] xc, logic [9:0] yc);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        start <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    start <= 1; operation <= op; x_coord <= xc; y_coord <= yc;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_word(op, xc, yc);
    words_sent++;
    if (op == spf_pkg::OpQuery) queries++;
    @(negedge clk);
  endtask

  function automatic logic [9:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 10'd0;
      1: return 10'd1023;
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic random_polygon();
    int n;
    n = $urandom_range(0, 9) == 0 ? $urandom_range(17, 19) : $urandom_range(3, 8);
    send_word(spf_pkg::OpStart, rnd_coord(), rnd_coord());
    for (int i = 1; i < n; i++) send_word(spf_pkg::OpAppend, rnd_coord(), rnd_coord());
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: queries on an empty store, a single vertex, a square, extremes
    send_word(spf_pkg::OpQuery, 10'd0, 10'd5);
    send_word(spf_pkg::OpAppend, 10'd100, 10'd100);
    send_word(spf_pkg::OpQuery, 10'd1023, 10'd100);
    send_word(spf_pkg::OpAppend, 10'd1023, 10'd100);
    send_word(spf_pkg::OpAppend, 10'd1023, 10'd1023);
    send_word(spf_pkg::OpAppend, 10'd100, 10'd1023);
    send_word(spf_pkg::OpQuery, 10'd0, 10'd100);
    send_word(spf_pkg::OpQuery, 10'd0, 10'd500);
    send_word(spf_pkg::OpQuery, 10'd0, 10'd1023);
    send_word(spf_pkg::OpNop, 10'd1023, 10'd1023);
    send_word(spf_pkg::OpStart, 10'd0, 10'd0);
    send_word(spf_pkg::OpAppend, 10'd1023, 10'd1023);
    send_word(spf_pkg::OpAppend, 10'd0, 10'd1023);
    send_word(spf_pkg::OpQuery, 10'd0, 10'd0);
    send_word(spf_pkg::OpQuery, 10'd0, 10'd511);
    send_word(spf_pkg::OpQuery, 10'd0, 10'd1022);
    for (int i = 0; i < 17; i++)
      send_word(i == 0 ? spf_pkg::OpStart : spf_pkg::OpAppend, 10'(i * 60),
                (i % 2) ? 10'd1000 : 10'd3);
    send_word(spf_pkg::OpQuery, 10'd0, 10'd500);
    // random polygons followed by queries, with some stray words
    while (words_sent < 195) begin
      random_polygon();
      repeat ($urandom_range(2, 6)) begin
        if ($urandom_range(0, 9) == 0) send_word(spf_pkg::OpNop, rnd_coord(), rnd_coord());
        send_word(spf_pkg::OpQuery, rnd_coord(), rnd_coord());
      end
    end
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    $display("Sent %0d words including %0d scanline queries; %0d span words checked.",
             words_sent, queries, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS scanline_polygon_span_fill");
    end else begin
      $display("FAIL scanline_polygon_span_fill");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+hdl
hdl/spf_pkg.sv
hdl/spf_ram.sv
hdl/spf_datapath.sv
hdl/spf_ctrl.sv
hdl/scanline_polygon_span_fill.sv
tb/tb_top.sv
